[design/assert_macros.svh]
// Assertion macros used by the checker of the checksum unit.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Condition that must hold in the cycle after reset is seen.
`define ASSERT_AFTER_RST(label, clk, rst, cons, msg) \
  label: assert property (@(posedge clk) (rst) |=> (cons)) else $error(msg);

`endif

[design/ipphc_pkg.sv]
// Shared types, constants and helpers of the IPv4 pseudo-header checksum unit.
// Depends on nothing.
package ipphc_pkg;

  // Entry queue between the byte parser and the summing back end.
  localparam int unsigned QUEUE_DEPTH = 4;   // power of two
  localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W = QPTR_W + 1;
  localparam logic [QCNT_W-1:0] QUEUE_FULL_COUNT = QCNT_W'(QUEUE_DEPTH);

  // Byte position inside the packet; saturates at 63, past the longest header of 60 bytes.
  localparam int unsigned POS_W = 6;
  localparam logic [POS_W-1:0] POS_MAX       = '1;
  localparam logic [POS_W-1:0] MIN_HDR_BYTES = 6'd20;
  localparam logic [POS_W-1:0] SRC_FIRST     = 6'd12;
  localparam logic [POS_W-1:0] SRC_LAST      = 6'd15;
  localparam logic [POS_W-1:0] DST_FIRST     = 6'd16;
  localparam logic [POS_W-1:0] DST_LAST      = 6'd19;
  localparam logic [POS_W-1:0] OPT_FIRST     = 6'd20;

  localparam logic [3:0] MIN_IHL = 4'd5;

  // IP option codes and length rules.
  localparam logic [7:0] OPT_EOL       = 8'd0;
  localparam logic [7:0] OPT_NOP       = 8'd1;
  localparam logic [7:0] OPT_LSRR      = 8'd131;
  localparam logic [7:0] OPT_SSRR      = 8'd137;
  localparam logic [7:0] MIN_OPT_LEN   = 8'd2;
  localparam logic [7:0] MIN_ROUTE_LEN = 8'd7;

  // Option walk offsets: kind byte, length byte, then the body.
  localparam logic [7:0] OFS_KIND = 8'd0;
  localparam logic [7:0] OFS_LEN  = 8'd1;
  localparam logic [7:0] OFS_BODY = 8'd2;

  typedef enum logic {
    ENTRY_WORD,
    ENTRY_END
  } entry_kind_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [15:0] upper_length;
    logic [7:0]  next_protocol;
  } in_item_t;

  typedef struct packed {
    logic [15:0] checksum;
    logic        used_source_route;
    logic [31:0] final_destination;
  } out_item_t;

  // One queue entry: a payload word to sum, or the close of a packet with
  // its tail word and the pseudo-header fields.
  typedef struct packed {
    entry_kind_t kind;
    logic [15:0] word;
    logic [31:0] source;
    logic [31:0] dest;
    logic        route;
    logic [7:0]  protocol;
    logic [15:0] length;
  } q_entry_t;

  // Ones' complement add with end-around carry.
  function automatic logic [15:0] add_fold16(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

endpackage

[design/ipv4_pseudo_header_checksum_unit.sv]
// IPv4 pseudo-header checksum unit: one packet byte per cycle in, one result per packet out.
// Result path: the packet close passes the queue, stages s1 and s2 and the result register.
// Throughput: one byte every cycle; input stalls only when the 4-entry queue fills
//   behind an output beat that is not taken.
// Reset: synchronous, active high; clears parser, queue pointers, accumulator and pipe valids.
// Depends on ipphc_pkg, ipphc_front, ipphc_queue, ipphc_back.
module ipv4_pseudo_header_checksum_unit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  ipphc_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ipphc_pkg::out_item_t out_data
);

  // Front to queue: one entry per completed payload word or packet close.
  logic                push_valid;
  ipphc_pkg::q_entry_t push_entry;
  logic                queue_full;

  // Queue to back end.
  logic                head_valid;
  ipphc_pkg::q_entry_t head;
  logic                pop;

  // Parse header bytes, walk options for a source route, pair payload bytes.
  // Hold input whenever the queue is full, whether or not this beat makes an entry.
  ipphc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .queue_full (queue_full),
    .push_valid (push_valid),
    .push_entry (push_entry)
  );

  // Decouple the parser from output backpressure.
  ipphc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_entry (push_entry),
    .full       (queue_full),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  // Accumulate payload words; on a packet close add the pseudo-header terms
  // in a two-stage adder tree, fold, complement and register the result beat.
  ipphc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

[design/ipphc_front.sv]
// Byte parser of the checksum unit: header capture, option walk, word pairing.
// Depends on ipphc_pkg; feeds ipphc_queue.
module ipphc_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  ipphc_pkg::in_item_t in_data,
  input  logic                queue_full,
  output logic                push_valid,
  output ipphc_pkg::q_entry_t push_entry
);

  logic [ipphc_pkg::POS_W-1:0] byte_position, byte_position_next;
  logic [ipphc_pkg::POS_W-1:0] header_bytes, header_bytes_next;
  logic [7:0]  pending_high_byte, pending_high_byte_next;
  logic        odd_byte_flag, odd_byte_flag_next;
  logic [31:0] source_address, source_address_next;
  logic [31:0] header_destination, header_destination_next;
  logic [31:0] route_destination, route_destination_next;
  logic        route_found, route_found_next;
  logic        walk_stopped, walk_stopped_next;
  logic [7:0]  option_kind, option_kind_next;
  logic [7:0]  option_length, option_length_next;
  logic [7:0]  option_offset, option_offset_next;
  logic [31:0] recent_four_bytes, recent_four_bytes_next;
  logic [15:0] latched_length, latched_length_next;
  logic [7:0]  latched_protocol, latched_protocol_next;

  logic                        accept;
  logic [7:0]                  b;
  logic                        pos_zero;
  logic [ipphc_pkg::POS_W-1:0] hb_now;
  logic [ipphc_pkg::POS_W-1:0] rem;
  logic                        in_header;
  logic                        word_done;
  logic [15:0]                 word;
  logic [7:0]                  ofs_inc;

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;
  assign b        = in_data.data_byte;
  assign pos_zero = (byte_position == '0);

  always_comb begin
    byte_position_next      = byte_position;
    header_bytes_next       = header_bytes;
    pending_high_byte_next  = pending_high_byte;
    odd_byte_flag_next      = odd_byte_flag;
    source_address_next     = source_address;
    header_destination_next = header_destination;
    route_destination_next  = route_destination;
    route_found_next        = route_found;
    walk_stopped_next       = walk_stopped;
    option_kind_next        = option_kind;
    option_length_next      = option_length;
    option_offset_next      = option_offset;
    recent_four_bytes_next  = recent_four_bytes;
    latched_length_next     = latched_length;
    latched_protocol_next   = latched_protocol;
    word_done               = 1'b0;
    word                    = 16'h0000;
    ofs_inc                 = option_offset + 8'd1;

    // Header length comes from the first byte; short IHL means 20 bytes.
    if (pos_zero) begin
      hb_now = (b[3:0] < ipphc_pkg::MIN_IHL) ? ipphc_pkg::MIN_HDR_BYTES : {b[3:0], 2'b00};
      header_bytes_next     = hb_now;
      latched_length_next   = in_data.upper_length;
      latched_protocol_next = in_data.next_protocol;
    end else begin
      hb_now = header_bytes;
    end

    in_header = pos_zero || (byte_position < hb_now);
    // Bytes left in the header counted from the option's kind byte.
    rem = hb_now - byte_position + 6'd1;

    if (in_header) begin
      if (byte_position >= ipphc_pkg::SRC_FIRST && byte_position <= ipphc_pkg::SRC_LAST) begin
        unique case (byte_position[1:0])
          2'd0: source_address_next[31:24] = b;
          2'd1: source_address_next[23:16] = b;
          2'd2: source_address_next[15:8]  = b;
          2'd3: source_address_next[7:0]   = b;
        endcase
      end else if (byte_position >= ipphc_pkg::DST_FIRST &&
                   byte_position <= ipphc_pkg::DST_LAST) begin
        unique case (byte_position[1:0])
          2'd0: header_destination_next[31:24] = b;
          2'd1: header_destination_next[23:16] = b;
          2'd2: header_destination_next[15:8]  = b;
          2'd3: header_destination_next[7:0]   = b;
        endcase
      end else if (byte_position >= ipphc_pkg::OPT_FIRST && !walk_stopped && !route_found) begin
        priority if (option_offset == ipphc_pkg::OFS_KIND) begin
          option_kind_next = b;
          if (b == ipphc_pkg::OPT_EOL) begin
            walk_stopped_next = 1'b1;
          end else if (b != ipphc_pkg::OPT_NOP) begin
            option_offset_next = ipphc_pkg::OFS_LEN;
          end
        end else if (option_offset == ipphc_pkg::OFS_LEN) begin
          // Stop on a bad length or one that runs past the header.
          if (b < ipphc_pkg::MIN_OPT_LEN || {2'b00, rem} < b) begin
            walk_stopped_next = 1'b1;
          end else begin
            option_length_next = b;
            option_offset_next = (b == ipphc_pkg::MIN_OPT_LEN) ? ipphc_pkg::OFS_KIND
                                                                : ipphc_pkg::OFS_BODY;
          end
        end else begin
          recent_four_bytes_next = {recent_four_bytes[23:0], b};
          if (ofs_inc >= option_length) begin
            option_offset_next = ipphc_pkg::OFS_KIND;
            if ((option_kind == ipphc_pkg::OPT_SSRR || option_kind == ipphc_pkg::OPT_LSRR) &&
                option_length >= ipphc_pkg::MIN_ROUTE_LEN) begin
              route_destination_next = recent_four_bytes_next;
              route_found_next       = 1'b1;
            end
          end else begin
            option_offset_next = ofs_inc;
          end
        end
      end
    end else if (odd_byte_flag) begin
      word               = {pending_high_byte, b};
      word_done          = 1'b1;
      odd_byte_flag_next = 1'b0;
    end else begin
      // Odd byte; padded with a zero low byte if the packet ends here.
      word                   = {b, 8'h00};
      pending_high_byte_next = b;
      odd_byte_flag_next     = 1'b1;
    end

    if (byte_position != ipphc_pkg::POS_MAX) begin
      byte_position_next = byte_position + 6'd1;
    end
  end

  assign push_valid = accept && (in_data.last_byte || word_done);

  always_comb begin
    push_entry.kind     = in_data.last_byte ? ipphc_pkg::ENTRY_END : ipphc_pkg::ENTRY_WORD;
    push_entry.word     = word;
    push_entry.source   = source_address_next;
    push_entry.dest     = route_found_next ? route_destination_next : header_destination_next;
    push_entry.route    = route_found_next;
    push_entry.protocol = latched_protocol_next;
    push_entry.length   = latched_length_next;
  end

  // The packet close returns every register to its reset value.
  always_ff @(posedge clk) begin
    if (rst || (accept && in_data.last_byte)) begin
      byte_position      <= '0;
      header_bytes       <= ipphc_pkg::MIN_HDR_BYTES;
      pending_high_byte  <= 8'h00;
      odd_byte_flag      <= 1'b0;
      source_address     <= 32'h0;
      header_destination <= 32'h0;
      route_destination  <= 32'h0;
      route_found        <= 1'b0;
      walk_stopped       <= 1'b0;
      option_kind        <= 8'h00;
      option_length      <= 8'h00;
      option_offset      <= ipphc_pkg::OFS_KIND;
      recent_four_bytes  <= 32'h0;
      latched_length     <= 16'h0;
      latched_protocol   <= 8'h00;
    end else if (accept) begin
      byte_position      <= byte_position_next;
      header_bytes       <= header_bytes_next;
      pending_high_byte  <= pending_high_byte_next;
      odd_byte_flag      <= odd_byte_flag_next;
      source_address     <= source_address_next;
      header_destination <= header_destination_next;
      route_destination  <= route_destination_next;
      route_found        <= route_found_next;
      walk_stopped       <= walk_stopped_next;
      option_kind        <= option_kind_next;
      option_length      <= option_length_next;
      option_offset      <= option_offset_next;
      recent_four_bytes  <= recent_four_bytes_next;
      latched_length     <= latched_length_next;
      latched_protocol   <= latched_protocol_next;
    end
  end

endmodule

[design/ipphc_queue.sv]
// Short entry FIFO between the byte parser and the summing back end.
// Depends on ipphc_pkg.
module ipphc_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push_valid,
  input  ipphc_pkg::q_entry_t push_entry,
  output logic                full,
  output logic                head_valid,
  output ipphc_pkg::q_entry_t head,
  input  logic                pop
);

  ipphc_pkg::q_entry_t               entries [ipphc_pkg::QUEUE_DEPTH];
  logic [ipphc_pkg::QPTR_W-1:0]      wr_ptr;
  logic [ipphc_pkg::QPTR_W-1:0]      rd_ptr;
  logic [ipphc_pkg::QCNT_W-1:0]      count;
  logic                              do_push;
  logic                              do_pop;

  assign full       = (count == ipphc_pkg::QUEUE_FULL_COUNT);
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];
  assign do_push    = push_valid && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

[design/ipphc_back.sv]
// Summing back end: payload word accumulator and the pseudo-header close pipe.
// Depends on ipphc_pkg; drains ipphc_queue.
module ipphc_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 head_valid,
  input  ipphc_pkg::q_entry_t  head,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ipphc_pkg::out_item_t out_data
);

  logic [15:0] acc;
  logic        advance;
  logic        is_end;

  logic        s1_valid;
  logic [16:0] s1_sum [4];
  logic        s1_route;
  logic [31:0] s1_dest;

  logic        s2_valid;
  logic [18:0] s2_total;
  logic        s2_route;
  logic [31:0] s2_dest;

  logic [16:0] fold1;
  logic [15:0] fold2;

  assign advance = !out_valid || out_ready;
  assign is_end  = (head.kind == ipphc_pkg::ENTRY_END);
  // Payload words never wait; a packet close waits for the pipe to move.
  assign pop     = head_valid && (!is_end || advance);

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= 16'h0;
    end else if (pop) begin
      acc <= is_end ? 16'h0 : ipphc_pkg::add_fold16(acc, head.word);
    end
  end

  // End-around carry folding of the wide total.
  assign fold1 = {1'b0, s2_total[15:0]} + {14'd0, s2_total[18:16]};
  assign fold2 = fold1[15:0] + {15'd0, fold1[16]};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      s1_valid  <= pop && is_end;
      s2_valid  <= s1_valid;
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_sum[0] <= {1'b0, acc} + {1'b0, head.word};
      s1_sum[1] <= {1'b0, head.source[31:16]} + {1'b0, head.source[15:0]};
      s1_sum[2] <= {1'b0, head.dest[31:16]} + {1'b0, head.dest[15:0]};
      s1_sum[3] <= {9'd0, head.protocol} + {1'b0, head.length};
      s1_route  <= head.route;
      s1_dest   <= head.dest;

      s2_total  <= {2'b00, s1_sum[0]} + {2'b00, s1_sum[1]} +
                   {2'b00, s1_sum[2]} + {2'b00, s1_sum[3]};
      s2_route  <= s1_route;
      s2_dest   <= s1_dest;

      out_data.checksum          <= ~fold2;
      out_data.used_source_route <= s2_route;
      out_data.final_destination <= s2_dest;
    end
  end

endmodule

[design/ipphc_checker.sv]
// Port-level checker for the checksum unit, bound to the top level.
// Depends on ipphc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ipphc_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_ready,
  input ipphc_pkg::in_item_t  in_data,
  input logic                 out_valid,
  input logic                 out_ready,
  input ipphc_pkg::out_item_t out_data
);

  // Packets closed at the input whose result beat has not been taken yet.
  logic [3:0] outstanding;
  logic       close_in;
  logic       result_out;

  assign close_in   = in_valid && in_ready && in_data.last_byte;
  assign result_out = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= 4'd0;
    end else begin
      unique case ({close_in, result_out})
        2'b10:   outstanding <= outstanding + 4'd1;
        2'b01:   outstanding <= outstanding - 4'd1;
        default: outstanding <= outstanding;
      endcase
    end
  end

  `ASSERT_AFTER_RST(a_no_result_after_reset, clk, rst, !out_valid, "result beat right after reset")

  `ASSERT_IMP(a_result_has_packet, clk, rst, out_valid, outstanding != 4'd0, "result with no packet closed")

  `ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result changed")

endmodule

bind ipv4_pseudo_header_checksum_unit ipphc_checker u_ipphc_checker (.*);
